/* rtl/core/deq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg: shared definitions of the double-ended queue
// Sizes, operation and status codes, and ring index arithmetic.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int DEPTH    = 16;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int WORD_W   = 32;
	localparam int MODE_W   = 3;
	localparam int STATUS_W = 2;

	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic [CNT_W-1:0]        cnt_t;
	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [MODE_W-1:0]       mode_t;
	typedef logic [STATUS_W-1:0]     status_t;

	localparam mode_t MODE_PUSH_FRONT = 3'd0;
	localparam mode_t MODE_PUSH_BACK  = 3'd1;
	localparam mode_t MODE_POP_FRONT  = 3'd2;
	localparam mode_t MODE_POP_BACK   = 3'd3;
	localparam mode_t MODE_LIST       = 3'd4;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	// Ring position that lies a given number of entries after a base index.
	// The offset never exceeds DEPTH, so one compare and subtract suffices.
	function automatic idx_t ring_add(input idx_t base, input cnt_t offset);
		logic [CNT_W:0] sum;
		sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(offset);
		if (sum >= (CNT_W + 1)'(DEPTH)) begin
			sum = sum - (CNT_W + 1)'(DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

	// Ring position of the entry just before a base index.
	function automatic idx_t ring_dec(input idx_t base);
		idx_t res;
		if (base == '0) begin
			res = IDX_W'(DEPTH - 1);
		end else begin
			res = base - 1'b1;
		end
		return res;
	endfunction

endpackage

/* rtl/core/deq_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_req_if: request channel of the double-ended queue
// Carries one operation code and the word to push per transaction.
// ----------------------------------------------------------------------------
interface deq_req_if;
	import deq_pkg::*;

	logic  valid;
	logic  ready;
	mode_t mode;
	word_t value;

	modport source (output valid, output mode, output value, input ready);
	modport sink   (input valid, input mode, input value, output ready);

endinterface

/* rtl/core/deq_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_rsp_if: response channel of the double-ended queue
// Carries one result word, its status and the final-result flag per transaction.
// ----------------------------------------------------------------------------
interface deq_rsp_if;
	import deq_pkg::*;

	logic    valid;
	logic    ready;
	word_t   word;
	status_t status;
	logic    last;

	modport source (output valid, output word, output status, output last, input ready);
	modport sink   (input valid, input word, input status, input last, output ready);

endinterface

/* rtl/core/double_ended_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed 32-bit words in a ring memory
// Push and pop at either end, or list all entries from front to back.
// ----------------------------------------------------------------------------
//
//  Channel | Role  | Payload               | One transaction is
//  --------+-------+-----------------------+---------------------------------
//  req     | sink  | mode, value           | one operation
//  rsp     | source| word, status, last    | one result (last marks the end)
//
//  A push, or a pop or list of an empty queue, loads its result into the
//  output register directly. A pop that returns a word and a list pass every
//  word through the single read port of the entry memory, whose read data is
//  registered, before it reaches the output register.
//  Reset clears the front index, the entry count and the control state; the
//  memory itself is not cleared, since only written entries are ever read.
//  A stalled response holds the output register; when idle, a new request is
//  taken as soon as that register is free or is being emptied in the same cycle.
// ----------------------------------------------------------------------------
module double_ended_queue (
	input  logic      clk,
	input  logic      arst_n,
	deq_req_if.sink   req,
	deq_rsp_if.source rsp
);
	import deq_pkg::*;

	// Controller states: idle takes requests, read streams words out of memory.
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_READ = 1'b1;

	logic state_q, state_d;

	// Queue bookkeeping.
	idx_t front_q, front_d;
	cnt_t cnt_q, cnt_d;

	// Read sequence: position of the word now in the read register, relative
	// to the front, and the position of the final word of the sequence.
	idx_t idx_q, idx_d;
	idx_t end_q, end_d;

	// Entry memory with one write port and one registered read port.
	word_t mem [DEPTH];
	word_t rd_q;
	logic  mem_we, mem_re;
	idx_t  mem_wa, mem_ra;

	// Output register.
	logic    out_valid_q;
	word_t   out_word_q;
	status_t out_status_q;
	logic    out_last_q;

	logic    out_free;
	logic    accept;
	logic    ld_out;
	word_t   ld_word;
	status_t ld_status;
	logic    ld_last;
	logic    full, empty;

	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE) && out_free;
	assign accept    = req.valid && req.ready;
	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign empty     = (cnt_q == '0);

	always_comb begin
		state_d   = state_q;
		front_d   = front_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		end_d     = end_q;
		mem_we    = 1'b0;
		mem_wa    = front_q;
		mem_re    = 1'b0;
		mem_ra    = front_q;
		ld_out    = 1'b0;
		ld_word   = '0;
		ld_status = ST_OK;
		ld_last   = 1'b1;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req.mode)
						MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
							ld_out = 1'b1;
							if (full) begin
								ld_status = ST_FULL;
							end else begin
								mem_we = 1'b1;
								cnt_d  = cnt_q + 1'b1;
								if (req.mode == MODE_PUSH_FRONT) begin
									// The new word goes just before the old front.
									mem_wa  = ring_dec(front_q);
									front_d = ring_dec(front_q);
								end else begin
									mem_wa = ring_add(front_q, cnt_q);
								end
							end
						end
						MODE_POP_FRONT, MODE_POP_BACK: begin
							if (empty) begin
								ld_out    = 1'b1;
								ld_status = ST_EMPTY;
							end else begin
								// Bookkeeping moves now; the word arrives next cycle.
								mem_re  = 1'b1;
								cnt_d   = cnt_q - 1'b1;
								idx_d   = '0;
								end_d   = '0;
								state_d = ST_READ;
								if (req.mode == MODE_POP_FRONT) begin
									front_d = ring_add(front_q, CNT_W'(1));
								end else begin
									mem_ra = ring_add(front_q, cnt_q - 1'b1);
								end
							end
						end
						MODE_LIST: begin
							if (empty) begin
								ld_out    = 1'b1;
								ld_status = ST_EMPTY;
							end else begin
								mem_re  = 1'b1;
								idx_d   = '0;
								end_d   = IDX_W'(cnt_q - 1'b1);
								state_d = ST_READ;
							end
						end
						default: begin
							// Unused codes are taken and dropped without a result.
						end
					endcase
				end
			end
			ST_READ: begin
				// One word per cycle while the output side keeps up; the next read
				// is issued in the same cycle the current word is handed over.
				if (out_free) begin
					ld_out  = 1'b1;
					ld_word = rd_q;
					ld_last = (idx_q == end_q);
					if (idx_q == end_q) begin
						state_d = ST_IDLE;
					end else begin
						idx_d  = idx_q + 1'b1;
						mem_re = 1'b1;
						mem_ra = ring_add(front_q, CNT_W'(idx_q) + 1'b1);
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			front_q     <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
			end_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
			end_q   <= end_d;
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			out_word_q   <= ld_word;
			out_status_q <= ld_status;
			out_last_q   <= ld_last;
		end
	end

	// Entry memory. Each operation touches it once per cycle at most, and a
	// write lands before any later read of the same entry is issued.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= req.value;
		end
		if (mem_re) begin
			rd_q <= mem[mem_ra];
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.word   = out_word_q;
	assign rsp.status = out_status_q;
	assign rsp.last   = out_last_q;

`ifndef SYNTHESIS
	// The entry count never passes the capacity of the ring.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("entry count exceeds capacity");

	// A push into a queue with room grows the count by exactly one.
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.mode == MODE_PUSH_FRONT || req.mode == MODE_PUSH_BACK) && !full)
		|=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("push did not grow the queue");

	// While a read sequence runs, a free output register is always refilled.
	a_read_feeds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ && out_free) |=> rsp.valid)
		else $error("read sequence left the output empty");

	// The read position never runs past the final word of its sequence.
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> idx_q <= end_q)
		else $error("read position past end of sequence");
`endif

endmodule
